// ===== src/utf8_latin_accent_folder_unit_assert.svh =====
// Assertion macros shared by the folder RTL
`ifndef UTF8_LATIN_ACCENT_FOLDER_UNIT_ASSERT_SVH
`define UTF8_LATIN_ACCENT_FOLDER_UNIT_ASSERT_SVH

// explicit clock and reset
`define UTF8LAF_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// block clock and reset
`define UTF8LAF_ASSERT(lbl, prop, msg) \
   `UTF8LAF_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

// ===== src/utf8laf_pkg.sv =====
`default_nettype none
package utf8laf_pkg;

   localparam logic [7:0] LEAD_LATIN1  = 8'hC3;
   localparam logic [7:0] LEAD_EXTA_HI = 8'hC5;
   localparam logic [7:0] CHAR_UNMAPPED = 8'h2E;
   localparam logic [7:0] CHAR_DIGIT_LO = 8'h31;
   localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFFSET   = 8'h20;

   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic REG_DOWNCASE = 1'b0;

   typedef enum logic [1:0] {
      LEAD_NONE  = 2'd0,
      LEAD_C3    = 2'd1,
      LEAD_C4    = 2'd2,
      LEAD_C5    = 2'd3
   } lead_type;

   localparam logic [511:0] FOLD_C3 = {"AAAAAA1CEEEEIIII", "DNOOOOO..UUUUY23",
                                       "aaaaaa4ceeeeiiii", "dnooooo..uuuuy5y"};
   localparam logic [511:0] FOLD_C4 = {"AaAaAaCcCcCcCcDd", "DdEeEeEeEeEeGgGg",
                                       "GgGgHhHhIiIiIiIi", "Ii67JjKkkLlLlLlL"};
   localparam logic [511:0] FOLD_C5 = {"lLlNnNnNnnnnOoOo", "Oo89RrRrRrSsSsSs",
                                       "SsTtTtTtUuUuUuUu", "UuUuWwYyYZzZzZzs"};
   localparam logic [159:0] PAIR_TAB = "..AeThssaethIJijOeoe";

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_string_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_run_last;
      logic       out_string_end;
   } rsp_type;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      logic       two;
      logic       string_end;
   } entry_type;

   function automatic logic [7:0] fold_char(lead_type lead, logic [5:0] idx);
      logic [8:0] off;
      off = {~idx, 3'b000};
      unique case (lead)
         LEAD_C3: fold_char = FOLD_C3[off +: 8];
         LEAD_C4: fold_char = FOLD_C4[off +: 8];
         LEAD_C5: fold_char = FOLD_C5[off +: 8];
         default: fold_char = CHAR_UNMAPPED;
      endcase
   endfunction

   function automatic logic [15:0] pair_bytes(logic [3:0] p);
      logic [3:0] rev;
      rev = 4'd9 - p;
      pair_bytes = PAIR_TAB[{rev, 4'b0000} +: 16];
   endfunction

   function automatic logic [7:0] lower_ascii(logic [7:0] b, logic mode);
      if (mode && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         lower_ascii = b + CASE_OFFSET;
      end else begin
         lower_ascii = b;
      end
   endfunction

endpackage
`default_nettype wire

// ===== src/utf8laf_front.sv =====
`default_nettype none
module utf8laf_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire utf8laf_pkg::req_type   req_item,
   input  wire logic                   downcase,
   input  wire logic                   queue_full,
   output logic                        req_stall,
   output logic                        push,
   output utf8laf_pkg::entry_type      push_item
);

   utf8laf_pkg::lead_type pend_ff, pend_in;
   logic                  accept;
   logic                  is_lead;
   logic [7:0]            b;
   logic [7:0]            c;
   logic [15:0]           pair;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign b         = req_item.in_byte;
   assign is_lead   = (b >= utf8laf_pkg::LEAD_LATIN1) && (b <= utf8laf_pkg::LEAD_EXTA_HI);

   always_comb begin
      if (b[7:6] == 2'b10) begin
         c = utf8laf_pkg::fold_char(pend_ff, b[5:0]);
      end else begin
         c = utf8laf_pkg::CHAR_UNMAPPED;
      end
      pair = utf8laf_pkg::pair_bytes(c[3:0]);
   end

   always_comb begin
      pend_in              = pend_ff;
      push                 = 1'b0;
      push_item.first      = utf8laf_pkg::lower_ascii(b, downcase);
      push_item.second     = '0;
      push_item.two        = 1'b0;
      push_item.string_end = req_item.in_string_end;
      if (accept) begin
         if (pend_ff == utf8laf_pkg::LEAD_NONE) begin
            if (is_lead && !req_item.in_string_end) begin
               pend_in = utf8laf_pkg::lead_type'(2'(b - utf8laf_pkg::LEAD_LATIN1 + 8'd1));
            end else begin
               push = 1'b1;
            end
         end else begin
            pend_in = utf8laf_pkg::LEAD_NONE;
            push    = 1'b1;
            priority if (c == utf8laf_pkg::CHAR_UNMAPPED) begin
               push_item.first = utf8laf_pkg::lower_ascii(b, downcase);
            end else if (c >= utf8laf_pkg::CHAR_DIGIT_LO && c <= utf8laf_pkg::CHAR_DIGIT_HI) begin
               push_item.first  = utf8laf_pkg::lower_ascii(pair[15:8], downcase);
               push_item.second = utf8laf_pkg::lower_ascii(pair[7:0], downcase);
               push_item.two    = 1'b1;
            end else begin
               push_item.first = utf8laf_pkg::lower_ascii(c, downcase);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= utf8laf_pkg::LEAD_NONE;
      end else begin
         pend_ff <= pend_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/utf8laf_queue.sv =====
`default_nettype none
module utf8laf_queue #(
   parameter int DEPTH = utf8laf_pkg::QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire utf8laf_pkg::entry_type push_item,
   input  wire logic                   pop,
   output utf8laf_pkg::entry_type      head,
   output logic                        empty,
   output logic                        full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   utf8laf_pkg::entry_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

`include "utf8_latin_accent_folder_unit_assert.svh"
`UTF8LAF_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH), "queue count over depth")
`UTF8LAF_ASSERT(a_no_overflow, full |-> !push, "push into full queue")
`UTF8LAF_ASSERT(a_no_underflow, empty |-> !pop, "pop from empty queue")

endmodule
`default_nettype wire

// ===== src/utf8laf_back.sv =====
`default_nettype none
module utf8laf_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire utf8laf_pkg::entry_type head,
   input  wire logic                   head_valid,
   input  wire logic                   rsp_stall,
   output logic                        pop,
   output logic                        rsp_valid,
   output utf8laf_pkg::rsp_type        rsp_item
);

   logic                 phase_ff, phase_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   utf8laf_pkg::rsp_type rsp_item_ff, rsp_item_in;
   logic                 load;
   logic                 last;

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign last = !head.two || phase_ff;
   assign pop  = load && last;

   always_comb begin
      phase_in                   = phase_ff;
      rsp_valid_in               = rsp_valid_ff && rsp_stall;
      rsp_item_in                = rsp_item_ff;
      if (load) begin
         phase_in                   = !last;
         rsp_valid_in               = 1'b1;
         rsp_item_in.out_byte       = phase_ff ? head.second : head.first;
         rsp_item_in.out_run_last   = last;
         rsp_item_in.out_string_end = last && head.string_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`include "utf8_latin_accent_folder_unit_assert.svh"
`UTF8LAF_ASSERT(a_phase_pair, phase_ff |-> (head_valid && head.two), "second byte without pair")
`UTF8LAF_ASSERT(a_end_on_last, (rsp_valid && rsp_item.out_string_end) |-> rsp_item.out_run_last, "string end off last byte")

endmodule
`default_nettype wire

// ===== src/utf8_latin_accent_folder_unit.sv =====
// A byte is queued and loaded from the queue head into the rsp register; a pair's second byte follows.
// Throughput: one input byte per cycle unless stalled, set by the single-byte output register.
// A two-letter fold gives two output bytes, matching the two input bytes it consumed.
// Reset is synchronous: pending lead, queue, output valid and downcase mode clear at once.
`default_nettype none
module utf8_latin_accent_folder_unit #(
   parameter int QUEUE_DEPTH = utf8laf_pkg::QUEUE_DEPTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire utf8laf_pkg::req_type                   req_item,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output utf8laf_pkg::rsp_type                        rsp_item,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [utf8laf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [utf8laf_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [utf8laf_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                        pready
);

   logic                   downcase_ff, downcase_in;
   logic                   push;
   utf8laf_pkg::entry_type push_item;
   logic                   pop;
   utf8laf_pkg::entry_type head;
   logic                   empty;
   logic                   full;
   logic                   reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[utf8laf_pkg::CSR_ADDR_W-1] == utf8laf_pkg::REG_DOWNCASE);

   always_comb begin
      downcase_in = downcase_ff;
      if (psel && penable && pwrite && reg_hit) begin
         downcase_in = pwdata[0];
      end
      prdata = reg_hit ? {{(utf8laf_pkg::CSR_DATA_W-1){1'b0}}, downcase_ff} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         downcase_ff <= 1'b0;
      end else begin
         downcase_ff <= downcase_in;
      end
   end

   utf8laf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .downcase   (downcase_ff),
      .queue_full (full),
      .req_stall  (req_stall),
      .push       (push),
      .push_item  (push_item)
   );

   utf8laf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   utf8laf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!empty),
      .rsp_stall  (rsp_stall),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

endmodule
`default_nettype wire
